[hdl/bitmap_index_allocator_core_defines.svh]
// Assertion macros for the checker file bia_chk.sv.
`ifndef BITMAP_INDEX_ALLOCATOR_CORE_DEFINES_SVH
`define BITMAP_INDEX_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define BIA_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define BIA_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/bia_pkg.sv]
`default_nettype none

package bia_pkg;

  localparam int MAP_WORDS  = 1024;
  localparam int MAP_AW     = $clog2(MAP_WORDS);
  localparam int WORD_W     = 32;
  localparam int BIT_W      = 5;
  localparam int IDX_W      = 15;
  // word pointer one bit wider than the word part of an index
  localparam int WPTR_W     = IDX_W - BIT_W + 1;
  localparam int MAP_BITS   = MAP_WORDS * WORD_W;
  localparam int FAIL_LIMIT = 'h7FFF;
  localparam int SCAN_LIMIT = (MAP_BITS < FAIL_LIMIT) ? MAP_BITS : FAIL_LIMIT;
  localparam int SCAN_WORDS = (SCAN_LIMIT + WORD_W - 1) / WORD_W;
  localparam logic [IDX_W-1:0] START_CAP = 15'h6FFF;

  localparam int S_TDATA_W  = 32;
  localparam int M_TDATA_W  = 48;
  localparam int SERIAL_W   = 32;

  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_ALLOC    = 2'd0,
    STATUS_NOFREE   = 2'd1,
    STATUS_RELEASED = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_FINISH
  } state_e;

endpackage

`default_nettype wire

[hdl/bia_ram.sv]
`default_nettype none

module bia_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[hdl/bia_find.sv]
`default_nettype none

module bia_find (
  input  logic [bia_pkg::WORD_W-1:0] word_i,
  input  logic [bia_pkg::BIT_W-1:0]  start_bit_i,
  output logic                       hit_o,
  output logic [bia_pkg::BIT_W-1:0]  pos_o
);
  import bia_pkg::*;

  logic [WORD_W-1:0] masked;

  // lowest set bit at or above start_bit_i
  always_comb begin
    masked = word_i & ({WORD_W{1'b1}} << start_bit_i);
    hit_o  = |masked;
    pos_o  = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (masked[b]) begin
        pos_o = BIT_W'(b);
      end
    end
  end

endmodule

`default_nettype wire

[hdl/bitmap_index_allocator_core.sv]
// Channel  Dir  tdata (low bit up)                          tuser
// s_axis   in   has_min, min_index[15], release_index[15]   cmd
// m_axis   out  granted_index[15], unique_id[32]            status
//
// A release goes through S_READ, S_CHECK and S_FINISH; an allocate repeats S_READ and S_CHECK
// once per bitmap word visited, W words (one RAM read and one pass through the shared
// first-free finder per word), then goes to S_FINISH; worst case W is 1024.
// After reset the bitmap RAM is swept to all free, one word a cycle, with
// s_axis_tready_o low. A stalled result holds the sequencer before writeback.
`default_nettype none

module bitmap_index_allocator_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // has_min[0], min_index[15:1], release_index[30:16], zero[31]
  input  logic [bia_pkg::S_TDATA_W-1:0]    s_axis_tdata_i,
  // cmd[0]
  input  logic                             s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // granted_index[14:0], unique_id[46:15], zero[47]
  output logic [bia_pkg::M_TDATA_W-1:0]    m_axis_tdata_o,
  // status[1:0]
  output logic [1:0]                       m_axis_tuser_o
);
  import bia_pkg::*;

  state_e                state_q, state_d;
  logic [MAP_AW-1:0]     clr_q, clr_d;
  logic [IDX_W-1:0]      last_q, last_d;
  logic [SERIAL_W-1:0]   serial_q, serial_d;
  logic                  m_valid_q, m_valid_d;

  cmd_e                  cmd_q, cmd_d;
  logic [WPTR_W-1:0]     wptr_q, wptr_d;
  logic [BIT_W-1:0]      sbit_q, sbit_d;
  logic                  wr_q, wr_d;
  logic [WORD_W-1:0]     wdata_q, wdata_d;
  logic [IDX_W-1:0]      res_idx_q, res_idx_d;
  logic [SERIAL_W-1:0]   res_id_q, res_id_d;
  status_e               res_st_q, res_st_d;
  logic [IDX_W-1:0]      m_idx_q, m_idx_d;
  logic [SERIAL_W-1:0]   m_id_q, m_id_d;
  status_e               m_st_q, m_st_d;

  logic                  ram_we;
  logic [MAP_AW-1:0]     ram_waddr;
  logic [WORD_W-1:0]     ram_wdata;
  logic [WORD_W-1:0]     ram_rdata;
  logic                  hit;
  logic [BIT_W-1:0]      pos;

  logic                  in_acc;
  logic                  commit;
  logic                  has_min;
  logic [IDX_W-1:0]      min_index;
  logic [IDX_W-1:0]      rel_index;
  logic [IDX_W:0]        after;
  logic [IDX_W:0]        bigger;
  logic [IDX_W:0]        start;
  logic [IDX_W-1:0]      cand;
  logic [WPTR_W-1:0]     wnext;
  logic                  rel_in_map;
  logic                  start_off;
  logic                  cand_off;
  logic                  wnext_off;

  assign has_min   = s_axis_tdata_i[0];
  assign min_index = s_axis_tdata_i[IDX_W:1];
  assign rel_index = s_axis_tdata_i[2*IDX_W:IDX_W+1];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign commit          = (state_q == S_FINISH) && (!m_valid_q || m_axis_tready_i);

  always_comb begin
    after  = {1'b0, last_q} + 1'b1;
    bigger = ({1'b0, min_index} > after) ? {1'b0, min_index} : after;
    if (has_min) begin
      start = (bigger > {1'b0, START_CAP}) ? {1'b0, START_CAP} : bigger;
    end else begin
      start = after;
    end
  end

  assign rel_in_map = int'(rel_index[IDX_W-1:BIT_W]) < MAP_WORDS;
  assign start_off  = int'(start) >= SCAN_LIMIT;
  assign cand       = {wptr_q[IDX_W-BIT_W-1:0], pos};
  assign cand_off   = int'(cand) >= SCAN_LIMIT;
  assign wnext      = wptr_q + 1'b1;
  assign wnext_off  = int'(wnext) >= SCAN_WORDS;

  bia_find u_find (
    .word_i      (ram_rdata),
    .start_bit_i (sbit_q),
    .hit_o       (hit),
    .pos_o       (pos)
  );

  bia_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (MAP_AW'(wptr_q)),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_q == MAP_AW'(MAP_WORDS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser_i == CMD_RELEASE) begin
            state_d = rel_in_map ? S_READ : S_FINISH;
          end else begin
            state_d = start_off ? S_FINISH : S_READ;
          end
        end
      end
      S_READ: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (cmd_q == CMD_ALLOC && !hit && !wnext_off) begin
          state_d = S_READ;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (commit) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // datapath and RAM controls
  always_comb begin
    clr_d     = clr_q;
    last_d    = last_q;
    serial_d  = serial_q;
    cmd_d     = cmd_q;
    wptr_d    = wptr_q;
    sbit_d    = sbit_q;
    wr_d      = wr_q;
    wdata_d   = wdata_q;
    res_idx_d = res_idx_q;
    res_id_d  = res_id_q;
    res_st_d  = res_st_q;
    m_idx_d   = m_idx_q;
    m_id_d    = m_id_q;
    m_st_d    = m_st_q;
    m_valid_d = m_axis_tready_i ? 1'b0 : m_valid_q;
    ram_we    = 1'b0;
    ram_waddr = MAP_AW'(wptr_q);
    ram_wdata = wdata_q;

    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '1;
        clr_d     = clr_q + 1'b1;
      end
      S_IDLE: begin
        if (in_acc) begin
          cmd_d     = cmd_e'(s_axis_tuser_i);
          wr_d      = 1'b0;
          res_idx_d = '0;
          res_id_d  = '0;
          if (s_axis_tuser_i == CMD_RELEASE) begin
            wptr_d   = {1'b0, rel_index[IDX_W-1:BIT_W]};
            sbit_d   = rel_index[BIT_W-1:0];
            res_st_d = STATUS_RELEASED;
          end else begin
            wptr_d   = start[IDX_W:BIT_W];
            sbit_d   = start[BIT_W-1:0];
            res_st_d = STATUS_NOFREE;
            if (start_off) begin
              last_d = '0;
            end
          end
        end
      end
      S_READ: begin
      end
      S_CHECK: begin
        if (cmd_q == CMD_RELEASE) begin
          wdata_d = ram_rdata | (WORD_W'(1) << sbit_q);
          wr_d    = 1'b1;
        end else if (hit && !cand_off) begin
          wdata_d   = ram_rdata & ~(WORD_W'(1) << pos);
          wr_d      = 1'b1;
          res_idx_d = cand;
          res_id_d  = serial_q;
          res_st_d  = STATUS_ALLOC;
          serial_d  = serial_q + 1'b1;
          last_d    = (cand > START_CAP) ? '0 : cand;
        end else if (hit || wnext_off) begin
          last_d = '0;
        end else begin
          // advance to the next word, whole word eligible
          wptr_d = wnext;
          sbit_d = '0;
        end
      end
      S_FINISH: begin
        if (commit) begin
          ram_we    = wr_q;
          m_valid_d = 1'b1;
          m_idx_d   = res_idx_q;
          m_id_d    = res_id_q;
          m_st_d    = res_st_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      last_q    <= '0;
      serial_q  <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      last_q    <= last_d;
      serial_q  <= serial_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    wptr_q    <= wptr_d;
    sbit_q    <= sbit_d;
    wr_q      <= wr_d;
    wdata_q   <= wdata_d;
    res_idx_q <= res_idx_d;
    res_id_q  <= res_id_d;
    res_st_q  <= res_st_d;
    m_idx_q   <= m_idx_d;
    m_id_q    <= m_id_d;
    m_st_q    <= m_st_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {1'b0, m_id_q, m_idx_q};
  assign m_axis_tuser_o  = m_st_q;

endmodule

`default_nettype wire

[hdl/bia_chk.sv]
`default_nettype none
`include "bitmap_index_allocator_core_defines.svh"

module bia_chk (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  input  logic [bia_pkg::S_TDATA_W-1:0] s_tdata_i,
  input  logic                          s_tuser_i,
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  input  logic [bia_pkg::M_TDATA_W-1:0] m_tdata_i,
  input  logic [1:0]                    m_tuser_i
);
  import bia_pkg::*;

  `BIA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_tvalid_i && !m_tready_i, m_tvalid_i && $stable(m_tdata_i) && $stable(m_tuser_i), "stalled result changed")
  `BIA_ASSERT_NXT(a_busy_after_req, clk_i, rst_ni, s_tvalid_i && s_tready_i, !s_tready_i, "ready right after a request")
  `BIA_ASSERT_IMP(a_grant_range, clk_i, rst_ni, m_tvalid_i && m_tuser_i == STATUS_ALLOC, m_tdata_i[IDX_W-1:0] != '0 && m_tdata_i[IDX_W-1:0] != 15'h7FFF, "granted index out of range")
  `BIA_ASSERT_IMP(a_zero_payload, clk_i, rst_ni, m_tvalid_i && m_tuser_i != STATUS_ALLOC, m_tdata_i == '0, "non-grant result carries data")

  logic unused_in;
  assign unused_in = ^s_tdata_i ^ s_tuser_i;

endmodule

bind bitmap_index_allocator_core bia_chk u_bia_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid_i),
  .s_tready_i (s_axis_tready_o),
  .s_tdata_i  (s_axis_tdata_i),
  .s_tuser_i  (s_axis_tuser_i),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o),
  .m_tuser_i  (m_axis_tuser_o)
);

`default_nettype wire
